// ===== rtl/csg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csg_pkg: shared types and constants for the CSR sparse GEMV block
// Item kinds, the front-to-back queue word and storage sizes.
// ----------------------------------------------------------------------------
package csg_pkg;

  // Storage sizes
  localparam int unsigned X_DEPTH     = 1024;
  localparam int unsigned MAX_ROWS    = 65536;
  localparam int unsigned XAW         = $clog2(X_DEPTH);
  localparam int unsigned RW          = $clog2(MAX_ROWS);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QAW         = $clog2(QUEUE_DEPTH);

  // Field widths
  localparam int unsigned KIND_W = 2;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ROW_W  = 16;

  // Reset values of the gain registers (Q16.16)
  localparam logic [DATA_W-1:0] ALPHA_RESET = 32'h0001_0000;
  localparam logic [DATA_W-1:0] BETA_RESET  = 32'h0000_0000;

  // Register addresses (byte address bit 2 picks the register)
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BETA  = 1'b1;

  // Input word kinds; code 3 is unused
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  // Word handed from the front to the back
  typedef struct packed {
    logic                     close;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] x_val;
  } q_word_t;

endpackage

// ===== rtl/csg_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csg_ifs: stream channels of the CSR sparse GEMV block
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface csg_in_if import csg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [COL_W-1:0]         column;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, column, value, input ready);
  modport sink   (input valid, kind, column, value, output ready);
endinterface

interface csg_out_if import csg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         row_index;
  logic signed [DATA_W-1:0] y_value;
  logic                     saturated;

  modport source (output valid, row_index, y_value, saturated, input ready);
  modport sink   (input valid, row_index, y_value, saturated, output ready);
endinterface

// ===== rtl/csr_sparse_gemv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_gemv: sparse matrix-vector multiply, y = alpha*A*x + beta*y
// Top level: gain registers on the APB port, front, queue and back.
// ----------------------------------------------------------------------------
// Words stream in at one per cycle unless the output stalls: load words fill
// the 1024-entry x store, entry words multiply-accumulate value*x[column]
// into the row sum (Q48.16, saturating at 64 bits), and a close word
// carrying the old y yields one result alpha*sum + beta*old_y, saturated to
// 32 bits, then starts the next row. Throughput is one word per clock while
// the output flows, set by the single-ported x store read and the accumulate
// into the row sum; the result passes stages A to C2 and the output register.
// A four-word queue and the intake stage sit between intake and arithmetic,
// so up to five more entry or close words are taken while a result waits.
// Reading an x element never loaded since reset gives an undefined result.
// Program alpha_gain (0x0) and beta_gain (0x4) only while the block is idle.
module csr_sparse_gemv import csg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  csg_in_if.sink             in_i,
  csg_out_if.source          out_o
);

  logic signed [DATA_W-1:0] alpha_q, beta_q;
  logic                     q_full, q_push, q_valid, q_pop;
  q_word_t                  q_in_word, q_out_word;

  // Gain registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BETA) ? beta_q : alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      beta_q  <= BETA_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ALPHA) begin
        alpha_q <= pwdata;
      end else begin
        beta_q <= pwdata;
      end
    end
  end

  csg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_word_o (q_in_word)
  );

  csg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .word_i  (q_in_word),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .word_o  (q_out_word)
  );

  csg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_word_i  (q_out_word),
    .q_pop_o   (q_pop),
    .alpha_i   (alpha_q),
    .beta_i    (beta_q),
    .out_o     (out_o)
  );

endmodule

// ===== rtl/csg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csg_front: input word intake and x vector store
// Writes load words into the x store, fetches x for entry words and
// forwards entry and close words into the queue.
// ----------------------------------------------------------------------------
module csg_front import csg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  csg_in_if.sink    in_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output q_word_t   q_word_o
);

  logic [DATA_W-1:0] x_mem [X_DEPTH];

  logic                     accept;
  logic                     col_ok;
  logic [XAW-1:0]           addr;
  kind_e                    kind;
  logic                     fwd_d, fwd_q;
  logic                     close_q;
  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] x_rd_q;

  // Stage register may take a word when empty or draining this cycle
  assign in_i.ready = !fwd_q || !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign kind       = kind_e'(in_i.kind);
  assign col_ok     = 32'(in_i.column) < X_DEPTH;
  assign addr       = XAW'(in_i.column);

  // Classify: only in-range entries and row closes go on
  always_comb begin
    fwd_d = fwd_q && q_full_i;
    if (accept) begin
      case (kind)
        KIND_ENTRY: fwd_d = col_ok;
        KIND_CLOSE: fwd_d = 1'b1;
        default:    fwd_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      close_q <= (kind == KIND_CLOSE);
      value_q <= in_i.value;
    end
  end

  // x store: write on load, registered read on entry
  always_ff @(posedge clk_i) begin
    if (accept && kind == KIND_LOAD && col_ok) begin
      x_mem[addr] <= in_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && kind == KIND_ENTRY) begin
      x_rd_q <= x_mem[addr];
    end
  end

  assign q_push_o       = fwd_q && !q_full_i;
  assign q_word_o.close = close_q;
  assign q_word_o.value = value_q;
  assign q_word_o.x_val = x_rd_q;

endmodule

// ===== rtl/csg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csg_queue: short queue between front and back
// Small circular buffer of queue words with a fill count.
// ----------------------------------------------------------------------------
module csg_queue import csg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_word_t word_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    pop_i,
  output q_word_t word_o
);

  q_word_t          buf_mem [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     count_q, count_d;

  assign full_o  = (count_q == (QAW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign word_o  = buf_mem[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_mem[wr_ptr_q] <= word_i;
    end
  end

endmodule

// ===== rtl/csg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csg_back: multiply-accumulate and row scaling pipeline
// Accumulates entry products into the row sum; on a row close forms
// alpha*row_sum + beta*old_y over stages A to C2 and saturates to 32 bits.
// ----------------------------------------------------------------------------
module csg_back import csg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  q_word_t                  q_word_i,
  output logic                     q_pop_o,
  input  logic signed [DATA_W-1:0] alpha_i,
  input  logic signed [DATA_W-1:0] beta_i,
  csg_out_if.source                out_o
);

  logic en;

  // Stage A: shared 32x32 multiplier
  logic                     a_valid_q, a_close_q;
  logic signed [63:0]       a_prod_q;
  logic signed [DATA_W-1:0] mul_b;

  // Stage B: row sum and row counter
  logic signed [63:0] row_sum_q, row_sum_d;
  logic signed [63:0] addend, acc_sum;
  logic [RW-1:0]      row_cnt_q;
  logic               b_valid_q;
  logic signed [63:0] b_rs_q, b_bp_q;
  logic [RW-1:0]      b_row_q;

  // Stage C1: alpha partial products
  logic               c_valid_q;
  logic signed [64:0] c_plo_q;
  logic signed [63:0] c_phi_q, c_bp_q;
  logic [RW-1:0]      c_row_q;

  // Stage C2: exact Q64.32 total
  logic               d_valid_q;
  logic signed [95:0] d_sum_q;
  logic [RW-1:0]      d_row_q;
  logic signed [95:0] sh_sum;
  logic               sat_hit;

  // Output register
  logic                     out_valid_q;
  logic [ROW_W-1:0]         out_row_q;
  logic signed [DATA_W-1:0] out_y_q;
  logic                     out_sat_q;

  // Whole pipeline moves while the output register can take a word
  assign en      = !out_valid_q || out_o.ready;
  assign q_pop_o = en && q_valid_i;

  assign mul_b = q_word_i.close ? beta_i : q_word_i.x_val;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_close_q <= q_word_i.close;
      a_prod_q  <= 64'(q_word_i.value) * 64'(mul_b);
    end
  end

  // Saturating accumulate of the floor-shifted product
  always_comb begin
    addend  = a_prod_q >>> 16;
    acc_sum = row_sum_q + addend;
    row_sum_d = acc_sum;
    if (row_sum_q[63] == addend[63] && acc_sum[63] != row_sum_q[63]) begin
      row_sum_d = row_sum_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      row_sum_q   <= '0;
      row_cnt_q   <= '0;
    end else if (en) begin
      a_valid_q   <= q_valid_i;
      b_valid_q   <= a_valid_q && a_close_q;
      c_valid_q   <= b_valid_q;
      d_valid_q   <= c_valid_q;
      out_valid_q <= d_valid_q;
      if (a_valid_q) begin
        if (a_close_q) begin
          row_sum_q <= '0;
          row_cnt_q <= (row_cnt_q == RW'(MAX_ROWS-1)) ? '0 : row_cnt_q + 1'b1;
        end else begin
          row_sum_q <= row_sum_d;
        end
      end
    end
  end

  // Close capture and scaling datapath
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_rs_q  <= row_sum_q;
      b_bp_q  <= a_prod_q;
      b_row_q <= row_cnt_q;
      c_plo_q <= 65'($signed({1'b0, b_rs_q[31:0]})) * 65'(alpha_i);
      c_phi_q <= 64'($signed(b_rs_q[63:32])) * 64'(alpha_i);
      c_bp_q  <= b_bp_q;
      c_row_q <= b_row_q;
      d_sum_q <= (96'(c_phi_q) <<< 32) + 96'(c_plo_q) + 96'(c_bp_q);
      d_row_q <= c_row_q;
    end
  end

  // Floor shift to Q16.16 and clip to 32 bits
  assign sh_sum  = d_sum_q >>> 16;
  assign sat_hit = !((sh_sum[95:31] == '0) || (sh_sum[95:31] == '1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_row_q <= ROW_W'(d_row_q);
      out_sat_q <= sat_hit;
      if (sat_hit) begin
        out_y_q <= d_sum_q[95] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
        out_y_q <= sh_sum[31:0];
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.row_index = out_row_q;
  assign out_o.y_value   = out_y_q;
  assign out_o.saturated = out_sat_q;

endmodule
